// ===== design/jts_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON token scanner package
// Scanner state codes, token kind codes and the character constants used by
// the scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

    // Scanner state.
    typedef enum logic [3:0] {
        ST_INITIAL   = 4'd0,
        ST_START     = 4'd1,
        ST_KEY       = 4'd2,
        ST_WAIT_KEY  = 4'd3,
        ST_DATA      = 4'd4,
        ST_STRING    = 4'd5,
        ST_NUMBER    = 4'd6,
        ST_WAIT_DATA = 4'd7,
        ST_ARRAY     = 4'd8,
        ST_END       = 4'd9
    } t_scan_state;

    // Token kinds.
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ARRAY = 2'd2;

    // Widths.
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DEPTH_W = 8;

    // Characters.
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DIGIT0 = 8'd48;
    localparam logic [7:0] CH_DIGIT9 = 8'd57;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

endpackage

// ===== design/json_token_scanner_top.sv =====
// ----------------------------------------------------------------------------
// JSON token scanner
// Streams keys, string and number values and bracketed arrays out of a JSON
// text, one byte in per unstalled cycle, at most one token byte or end marker out.
// ----------------------------------------------------------------------------
// The scanner takes one byte of JSON text in every clock cycle while its
// input side is open and gives at most one result per byte in the next
// cycle through an output register. A byte whose result is still waiting may
// be taken in the same cycle that the result is transferred, so the block
// sustains one byte per cycle whenever the output side is ready; the scanner
// state and nesting depth update once per byte taken. Bytes that produce
// no result clear only the output valid flag, not the payload. Assert
// first_byte on the first byte of each text to restart the scanner. A
// number that is still open when the text ends never gets its end marker.
module json_token_scanner_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [jts_pkg::CHAR_W-1:0]  i_text_byte,
    input  logic                        i_first_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_token_kind,
    output logic [jts_pkg::DEPTH_W-1:0] o_token_level,
    output logic [jts_pkg::CHAR_W-1:0]  o_token_byte,
    output logic                        o_byte_present,
    output logic                        o_token_end
);
    import jts_pkg::*;

    t_scan_state        r_state, n_state, cur_state;
    logic [DEPTH_W-1:0] r_depth, n_depth, cur_depth;
    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [DEPTH_W-1:0] r_level;
    logic [CHAR_W-1:0]  r_byte;
    logic               r_present;
    logic               r_end;

    logic               in_xfer;
    logic               emit;
    logic [1:0]         emit_kind;
    logic               emit_present;
    logic               emit_end;
    logic               is_quote;
    logic               is_digit;
    logic               depth_inc;
    logic               depth_dec;
    logic [CHAR_W-1:0]  c;

    // The input side is open whenever the output register is empty or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // A first byte restarts the scan before the byte is handled.
    assign c         = i_text_byte;
    assign cur_state = i_first_byte ? ST_INITIAL : r_state;
    assign cur_depth = i_first_byte ? '0 : r_depth;
    assign is_quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    assign is_digit  = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);

    // Next scanner state and depth control.
    always_comb begin
        n_state   = cur_state;
        depth_inc = 1'b0;
        depth_dec = 1'b0;
        unique case (cur_state)
            ST_START: begin
                if (is_quote) n_state = ST_KEY;
            end
            ST_KEY: begin
                if (is_quote) n_state = ST_WAIT_KEY;
            end
            ST_WAIT_KEY: begin
                if (c == CH_COLON) n_state = ST_DATA;
            end
            ST_DATA: begin
                if (is_quote) begin
                    n_state = ST_STRING;
                end else if (is_digit) begin
                    n_state = ST_NUMBER;
                end else if (c == CH_LBRACE) begin
                    depth_inc = 1'b1;
                    n_state   = ST_START;
                end else if (c == CH_LBRACK) begin
                    n_state = ST_ARRAY;
                end
            end
            ST_STRING: begin
                if (is_quote) n_state = ST_WAIT_DATA;
            end
            ST_NUMBER: begin
                if (!is_digit) begin
                    if (c == CH_COMMA) begin
                        n_state = ST_START;
                    end else if (c == CH_RBRACE) begin
                        depth_dec = 1'b1;
                        n_state   = ST_END;
                    end else begin
                        n_state = ST_WAIT_DATA;
                    end
                end
            end
            ST_WAIT_DATA: begin
                if (c == CH_COMMA) begin
                    n_state = ST_START;
                end else if (c == CH_RBRACE) begin
                    depth_dec = 1'b1;
                    n_state   = ST_END;
                end
            end
            ST_ARRAY: begin
                if (c == CH_RBRACK) n_state = ST_WAIT_DATA;
            end
            ST_END: begin
                if (cur_depth != '0) n_state = ST_START;
            end
            default: begin
                if (c == CH_LBRACE) begin
                    depth_inc = 1'b1;
                    n_state   = ST_START;
                end
            end
        endcase
    end

    // Saturating depth update.
    always_comb begin
        n_depth = cur_depth;
        if (depth_inc && (cur_depth != '1)) begin
            n_depth = cur_depth + 1'b1;
        end else if (depth_dec && (cur_depth != '0)) begin
            n_depth = cur_depth - 1'b1;
        end
    end

    // Result decode for the current byte.
    always_comb begin
        emit         = 1'b0;
        emit_kind    = KIND_KEY;
        emit_present = 1'b0;
        emit_end     = 1'b0;
        unique case (cur_state)
            ST_KEY: begin
                emit         = 1'b1;
                emit_kind    = KIND_KEY;
                emit_present = !is_quote;
                emit_end     = is_quote;
            end
            ST_DATA: begin
                if (is_digit) begin
                    emit         = 1'b1;
                    emit_kind    = KIND_VALUE;
                    emit_present = 1'b1;
                end else if (!is_quote && (c == CH_LBRACK)) begin
                    emit         = 1'b1;
                    emit_kind    = KIND_ARRAY;
                    emit_present = 1'b1;
                end
            end
            ST_STRING: begin
                emit         = 1'b1;
                emit_kind    = KIND_VALUE;
                emit_present = !is_quote;
                emit_end     = is_quote;
            end
            ST_NUMBER: begin
                emit         = 1'b1;
                emit_kind    = KIND_VALUE;
                emit_present = is_digit;
                emit_end     = !is_digit;
            end
            ST_ARRAY: begin
                emit         = 1'b1;
                emit_kind    = KIND_ARRAY;
                emit_present = 1'b1;
                emit_end     = (c == CH_RBRACK);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INITIAL;
            r_depth <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
            r_depth <= n_depth;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_kind    <= emit_kind;
            r_level   <= cur_depth;
            r_byte    <= emit_present ? c : '0;
            r_present <= emit_present;
            r_end     <= emit_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_kind;
    assign o_token_level  = r_level;
    assign o_token_byte   = r_byte;
    assign o_byte_present = r_present;
    assign o_token_end    = r_end;

`ifndef SYNTHESIS
    // Every result carries either a content byte or an end marker.
    a_byte_or_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_present || o_token_end))
        else $error("result with neither content byte nor end marker");

    // An array ends only on its closing bracket, which is carried as content.
    a_array_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == KIND_ARRAY && o_token_end)
        |-> (o_byte_present && o_token_byte == CH_RBRACK))
        else $error("array end without closing bracket");

    // The depth only changes when a byte is transferred in.
    a_depth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(in_xfer)) |-> $stable(r_depth))
        else $error("depth changed without an input transfer");

    // A waiting result is not overwritten by a byte that produces nothing.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result lost");
`endif

endmodule

// ===== verif/json_token_scanner_top_tb.sv =====
// ----------------------------------------------------------------------------
// JSON token scanner testbench
// Feeds hand-written and randomly built JSON texts into the scanner, predicts
// every token byte and end marker, and checks them in order against the
// output channel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module json_token_scanner_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jts_pkg::*;

    // One token result as seen on the output channel.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] level;
        logic [7:0] tbyte;
        logic       present;
        logic       closes;
    } t_token;

    // Predicts the scanner and checks its tokens in order of arrival.
    class t_token_scoreboard;
        t_token      expected_q[$];
        t_scan_state scan;
        logic [7:0]  depth;
        int          errors;
        int          checked;
        int          deepest;

        function new();
            scan    = ST_INITIAL;
            depth   = '0;
            errors  = 0;
            checked = 0;
            deepest = 0;
        endfunction

        function bit is_quote(logic [7:0] c);
            return c == CH_DQUOTE || c == CH_SQUOTE;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_DIGIT0 && c <= CH_DIGIT9;
        endfunction

        function void add_token(logic [1:0] kind, logic [7:0] c, logic present,
                                logic closes);
            t_token t;
            t.kind    = kind;
            t.level   = depth;
            t.tbyte   = present ? c : 8'h00;
            t.present = present;
            t.closes  = closes;
            expected_q.push_back(t);
        endfunction

        // A comma starts the next member, a closing brace leaves the object.
        function void close_value(logic [7:0] c);
            if (c == CH_COMMA) begin
                scan = ST_START;
            end else if (c == CH_RBRACE) begin
                if (depth != 8'h00) begin
                    depth = depth - 8'd1;
                end
                scan = ST_END;
            end else begin
                scan = ST_WAIT_DATA;
            end
        endfunction

        // Advances the prediction by one accepted byte. Returns 1 when the
        // byte is a first byte, changed the scanner or produced a token.
        function bit note_byte(logic [7:0] c, logic first);
            t_scan_state old_scan;
            logic [7:0]  old_depth;
            int          old_count;
            if (first) begin
                scan  = ST_INITIAL;
                depth = '0;
            end
            old_scan  = scan;
            old_depth = depth;
            old_count = expected_q.size();
            case (scan)
                ST_START: begin
                    if (is_quote(c)) begin
                        scan = ST_KEY;
                    end
                end
                ST_KEY: begin
                    if (is_quote(c)) begin
                        add_token(KIND_KEY, 8'h00, 1'b0, 1'b1);
                        scan = ST_WAIT_KEY;
                    end else begin
                        add_token(KIND_KEY, c, 1'b1, 1'b0);
                    end
                end
                ST_WAIT_KEY: begin
                    if (c == CH_COLON) begin
                        scan = ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (is_quote(c)) begin
                        scan = ST_STRING;
                    end else if (is_digit(c)) begin
                        add_token(KIND_VALUE, c, 1'b1, 1'b0);
                        scan = ST_NUMBER;
                    end else if (c == CH_LBRACE) begin
                        if (depth != 8'hFF) begin
                            depth = depth + 8'd1;
                        end
                        scan = ST_START;
                    end else if (c == CH_LBRACK) begin
                        add_token(KIND_ARRAY, c, 1'b1, 1'b0);
                        scan = ST_ARRAY;
                    end
                end
                ST_STRING: begin
                    if (is_quote(c)) begin
                        add_token(KIND_VALUE, 8'h00, 1'b0, 1'b1);
                        scan = ST_WAIT_DATA;
                    end else begin
                        add_token(KIND_VALUE, c, 1'b1, 1'b0);
                    end
                end
                ST_NUMBER: begin
                    // The end marker carries the depth from before a closing brace.
                    if (is_digit(c)) begin
                        add_token(KIND_VALUE, c, 1'b1, 1'b0);
                    end else begin
                        add_token(KIND_VALUE, 8'h00, 1'b0, 1'b1);
                        close_value(c);
                    end
                end
                ST_WAIT_DATA: begin
                    if (c == CH_COMMA || c == CH_RBRACE) begin
                        close_value(c);
                    end
                end
                ST_ARRAY: begin
                    add_token(KIND_ARRAY, c, 1'b1, c == CH_RBRACK);
                    if (c == CH_RBRACK) begin
                        scan = ST_WAIT_DATA;
                    end
                end
                ST_END: begin
                    // Inside a nested object the next byte is swallowed.
                    if (depth != 8'h00) begin
                        scan = ST_START;
                    end
                end
                default: begin
                    if (c == CH_LBRACE) begin
                        if (depth != 8'hFF) begin
                            depth = depth + 8'd1;
                        end
                        scan = ST_START;
                    end
                end
            endcase
            if (int'(depth) > deepest) begin
                deepest = int'(depth);
            end
            return first || scan != old_scan || depth != old_depth ||
                   expected_q.size() != old_count;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        // Compares one transferred token with the oldest prediction.
        task check_token(t_token got);
            t_token want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected token kind %0d level %0d byte %02h",
                                 got.kind, got.level, got.tbyte));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.kind !== want.kind) begin
                report($sformatf("token %0d kind %0d, predicted %0d",
                                 checked, got.kind, want.kind));
            end
            if (got.level !== want.level) begin
                report($sformatf("token %0d level %0d, predicted %0d",
                                 checked, got.level, want.level));
            end
            if (got.tbyte !== want.tbyte) begin
                report($sformatf("token %0d byte %02h, predicted %02h",
                                 checked, got.tbyte, want.tbyte));
            end
            if (got.present !== want.present) begin
                report($sformatf("token %0d byte flag %b, predicted %b",
                                 checked, got.present, want.present));
            end
            if (got.closes !== want.closes) begin
                report($sformatf("token %0d end flag %b, predicted %b",
                                 checked, got.closes, want.closes));
            end
        endtask
    endclass

    // Clock, reset and block ports.
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_text_byte    = '0;
    logic       i_first_byte   = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready    = 1'b0;
    logic [1:0] o_token_kind;
    logic [7:0] o_token_level;
    logic [7:0] o_token_byte;
    logic       o_byte_present;
    logic       o_token_end;

    t_token_scoreboard sb = new();

    bit         calm_in      = 1'b0;
    bit         calm_out     = 1'b0;
    int         bytes_sent   = 0;
    int         live_bytes   = 0;
    int         texts_sent   = 0;
    bit [7:0]   text_q[$];

    json_token_scanner_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_first_byte   (i_first_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_level  (o_token_level),
        .o_token_byte   (o_token_byte),
        .o_byte_present (o_byte_present),
        .o_token_end    (o_token_end)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Presents one byte after a random gap and waits for its transfer.
    task automatic send_byte(input logic [7:0] c, input logic first);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            calm_in = !calm_in;
        end
        gap = calm_in ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= c;
        i_first_byte <= first;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (sb.note_byte(c, first)) begin
            live_bytes++;
        end
        bytes_sent++;
    endtask

    task automatic send_string(input string s, input logic first);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], first && i == 0);
        end
    endtask

    // Holds the input side off until every predicted token has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    function automatic bit [7:0] quote_char();
        return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    endfunction

    // Any byte that does not close a key or a string.
    function automatic void put_chars(int n);
        bit [7:0] c;
        repeat (n) begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (c == CH_DQUOTE || c == CH_SQUOTE);
            text_q.push_back(c);
        end
    endfunction

    function automatic void put_gap();
        if ($urandom_range(0, 3) == 0) begin
            text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
        end
    endfunction

    function automatic void put_value(int nest);
        bit [7:0] c;
        case ($urandom_range(0, nest > 0 ? 4 : 3))
            0: begin
                text_q.push_back(quote_char());
                put_chars($urandom_range(0, 6));
                text_q.push_back(quote_char());
            end
            1: begin
                repeat ($urandom_range(1, 5)) begin
                    text_q.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
                end
            end
            2: begin
                text_q.push_back(CH_LBRACK);
                repeat ($urandom_range(0, 6)) begin
                    do begin
                        c = 8'($urandom_range(0, 255));
                    end while (c == CH_RBRACK);
                    text_q.push_back(c);
                end
                text_q.push_back(CH_RBRACK);
            end
            3: begin
                // A bare word, null, passes through unseen.
                text_q.push_back(8'h6E);
                text_q.push_back(8'h75);
                text_q.push_back(8'h6C);
                text_q.push_back(8'h6C);
            end
            default: begin
                put_object(nest - 1);
            end
        endcase
    endfunction

    function automatic void put_object(int nest);
        int members;
        int i;
        members = $urandom_range(0, 4);
        text_q.push_back(CH_LBRACE);
        for (i = 0; i < members; i++) begin
            if (i > 0) begin
                text_q.push_back(CH_COMMA);
            end
            put_gap();
            text_q.push_back(quote_char());
            put_chars($urandom_range(0, 6));
            text_q.push_back(quote_char());
            put_gap();
            text_q.push_back(CH_COLON);
            put_gap();
            put_value(nest);
            put_gap();
        end
        text_q.push_back(CH_RBRACE);
    endfunction

    // Mostly well-formed objects, some cut short, corrupted or pure noise.
    function automatic void make_text();
        int shape;
        shape = $urandom_range(0, 19);
        text_q.delete();
        if (shape < 2) begin
            repeat ($urandom_range(1, 16)) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            if (shape == 2) begin
                repeat ($urandom_range(1, 3)) begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            put_object($urandom_range(0, 3));
            if (shape == 3 || shape == 4) begin
                repeat ($urandom_range(1, text_q.size() - 1)) begin
                    void'(text_q.pop_back());
                end
            end else if (shape == 5) begin
                repeat ($urandom_range(1, 3)) begin
                    text_q[$urandom_range(0, text_q.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
            end
        end
    endfunction

    // Output side: random stalls, one token transfer per loop.
    initial begin : take_tokens
        t_token got;
        int     stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                calm_out = !calm_out;
            end
            stall = calm_out ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
            got.kind    = o_token_kind;
            got.level   = o_token_level;
            got.tbyte   = o_token_byte;
            got.present = o_byte_present;
            got.closes  = o_token_end;
            sb.check_token(got);
        end
    end

    // Main stimulus sequence.
    initial begin : run_texts
        int  random_from;
        int  drain_at;
        int  waited;
        bit  drained;
        bit  first;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Key with a zero and an all-ones byte, mixed quotes, a skipped
        // letter before a number closed by a brace, then a dead byte at depth 0.
        send_byte(CH_LBRACE, 1'b1);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_string("':x1}z", 1'b0);
        texts_sent++;

        // Nested object holding an array with a quote inside, then a number
        // closed by a comma and a string value.
        send_string("{'':{\"\":[']},'':5,'':\"s\"}", 1'b1);
        texts_sent++;

        // Nesting well past the depth ceiling, a number ended by a space and
        // a number left open at the end of the text.
        send_byte(CH_LBRACE, 1'b1);
        repeat (256) send_string("'':{", 1'b0);
        send_string("\"k\":7 ,'':42", 1'b0);
        texts_sent++;
        hold_until_drained();

        // Random texts fill the run up to about 1250 bytes in total.
        random_from = bytes_sent;
        drain_at    = $urandom_range(40, 120);
        drained     = 1'b0;
        while (bytes_sent < 1250) begin
            make_text();
            first = $urandom_range(0, 19) != 0;
            foreach (text_q[i]) begin
                send_byte(text_q[i], first && i == 0);
            end
            texts_sent++;
            if (!drained && bytes_sent - random_from > drain_at) begin
                hold_until_drained();
                drained = 1'b1;
            end
        end

        // Let the last tokens drain, then watch for strays.
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d predicted tokens never arrived", sb.pending()));
        end

        $display("Sent %0d bytes (%0d of them live) in %0d texts, checked %0d tokens.",
                 bytes_sent, live_bytes, texts_sent, sb.checked);
        $display("Deepest nesting seen was %0d; %0d mismatches.",
                 sb.deepest, sb.errors);
        if (sb.errors == 0) begin
            $display("json_token_scanner_top verification clean");
        end else begin
            $display("json_token_scanner_top verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("json_token_scanner_top verification failed");
        $finish;
    end

endmodule
